// ----- rtl/lpi_pkg.sv -----
// Shared types and constants for the line point interpolator.
// Holds coordinate type, axis and controller state enums, and the
// command/status structs that join the controller to the datapath.
package lpi_pkg;

  localparam int COORD_W       = 6;
  localparam int LPI_COORD_MAX = 63;
  localparam int DIV_STEPS     = COORD_W;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_WAIT1,
    ST_DIV2,
    ST_WAIT2,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel;
    logic emit;
  } lpi_cmd_t;

  typedef struct packed {
    logic degenerate;
    logic div_done;
    logic slot_free;
    logic last;
  } lpi_status_t;

endpackage

// ----- rtl/lpi_divider.sv -----
// Serial restoring divider, one quotient bit per cycle.
// Depends on lpi_pkg for the coordinate width and step count.
module lpi_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lpi_pkg::coord_t dividend,
  input  lpi_pkg::coord_t divisor,
  output logic           busy,
  output logic           done,
  output lpi_pkg::coord_t quot,
  output lpi_pkg::coord_t rem
);
  import lpi_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [CNT_W-1:0] count;
  coord_t           shreg;
  coord_t           rem_reg;
  coord_t           dvs;
  logic [COORD_W:0] trial;
  logic [COORD_W:0] diff;
  logic             fits;

  assign trial = {rem_reg, shreg[COORD_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      // pulse done on the final shift only
      done <= busy && !start && (count == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg   <= dividend;
      rem_reg <= '0;
      dvs     <= divisor;
    end else if (busy) begin
      shreg   <= {shreg[COORD_W-2:0], fits};
      rem_reg <= fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
    end
  end

  assign quot = shreg;
  assign rem  = rem_reg;

endmodule

// ----- rtl/lpi_datapath.sv -----
// Datapath: endpoint clamp and axis pick, slope division, and per-point
// remainder stepping with a registered output stage.
// Depends on lpi_pkg and lpi_divider.
module lpi_datapath #(
  parameter int COORD_MAX = lpi_pkg::LPI_COORD_MAX
) (
  input  logic               clk,
  input  logic               rst,
  input  lpi_pkg::coord_t    a_x,
  input  lpi_pkg::coord_t    a_y,
  input  lpi_pkg::coord_t    a_z,
  input  lpi_pkg::coord_t    b_x,
  input  lpi_pkg::coord_t    b_y,
  input  lpi_pkg::coord_t    b_z,
  input  lpi_pkg::lpi_cmd_t  cmd,
  output lpi_pkg::lpi_status_t status,
  output lpi_pkg::coord_t    point_x,
  output lpi_pkg::coord_t    point_y,
  output lpi_pkg::coord_t    point_z,
  output logic               last_point,
  output logic               out_valid,
  input  logic               out_ready
);
  import lpi_pkg::*;

  typedef struct packed {
    coord_t           q;
    logic [COORD_W:0] r;
  } step_t;

  function automatic coord_t clamp(coord_t v);
    clamp = (v > coord_t'(COORD_MAX)) ? coord_t'(COORD_MAX) : v;
  endfunction

  // Advance one rounded coordinate by one step of the driving axis.
  function automatic step_t advance(coord_t q, logic [COORD_W:0] r, coord_t sq,
                                    coord_t sr, logic neg, coord_t d);
    logic [COORD_W+1:0] r_w;
    logic [COORD_W+1:0] sr_dbl;
    logic [COORD_W+1:0] d_dbl;
    logic [COORD_W+1:0] tmp;
    step_t              res;
    r_w    = {1'b0, r};
    sr_dbl = {1'b0, sr, 1'b0};
    d_dbl  = {1'b0, d, 1'b0};
    if (!neg) begin
      tmp = r_w + sr_dbl;
      if (tmp >= d_dbl) begin
        tmp   = tmp - d_dbl;
        res.q = q + sq + coord_t'(1);
      end else begin
        res.q = q + sq;
      end
    end else begin
      if (r_w < sr_dbl) begin
        tmp   = r_w + d_dbl - sr_dbl;
        res.q = q - sq - coord_t'(1);
      end else begin
        tmp   = r_w - sr_dbl;
        res.q = q - sq;
      end
    end
    res.r = tmp[COORD_W:0];
    return res;
  endfunction

  coord_t ca_x, ca_y, ca_z, cb_x, cb_y, cb_z;
  axis_t  in_axis;
  coord_t ta, tb, c1a, c1b, c2a, c2b;
  coord_t c1s, c1e, c2s, c2e, t_lo_in, t_hi_in;
  logic   a_first;
  logic   in_neg1, in_neg2;

  // held line state
  axis_t            axis;
  coord_t           t, t_hi, dspan;
  coord_t           mag1, mag2, base1, base2;
  logic             neg1, neg2;
  coord_t           sq1, sr1, sq2, sr2;
  coord_t           q1, q2;
  logic [COORD_W:0] r1, r2;
  logic             div_sel;

  logic   div_busy, div_done;
  coord_t div_quot, div_rem;
  step_t  nxt1, nxt2;
  coord_t v1, v2;
  coord_t px, py, pz;

  assign ca_x = clamp(a_x);
  assign ca_y = clamp(a_y);
  assign ca_z = clamp(a_z);
  assign cb_x = clamp(b_x);
  assign cb_y = clamp(b_y);
  assign cb_z = clamp(b_z);

  always_comb begin
    if (ca_y != cb_y) begin
      in_axis = AXIS_Y;
    end else if (ca_x != cb_x) begin
      in_axis = AXIS_X;
    end else begin
      in_axis = AXIS_Z;
    end
  end

  always_comb begin
    case (in_axis)
      AXIS_Y: begin
        ta = ca_y; tb = cb_y; c1a = ca_x; c1b = cb_x; c2a = ca_z; c2b = cb_z;
      end
      AXIS_X: begin
        ta = ca_x; tb = cb_x; c1a = ca_y; c1b = cb_y; c2a = ca_z; c2b = cb_z;
      end
      default: begin
        ta = ca_z; tb = cb_z; c1a = ca_x; c1b = cb_x; c2a = ca_y; c2b = cb_y;
      end
    endcase
  end

  assign a_first = ta < tb;
  assign t_lo_in = a_first ? ta : tb;
  assign t_hi_in = a_first ? tb : ta;
  assign c1s     = a_first ? c1a : c1b;
  assign c1e     = a_first ? c1b : c1a;
  assign c2s     = a_first ? c2a : c2b;
  assign c2e     = a_first ? c2b : c2a;
  assign in_neg1 = c1e < c1s;
  assign in_neg2 = c2e < c2s;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      axis  <= in_axis;
      t     <= t_lo_in;
      t_hi  <= t_hi_in;
      dspan <= t_hi_in - t_lo_in;
      neg1  <= in_neg1;
      neg2  <= in_neg2;
      mag1  <= in_neg1 ? c1s - c1e : c1e - c1s;
      mag2  <= in_neg2 ? c2s - c2e : c2e - c2s;
      base1 <= in_neg1 ? c1e : c1s;
      base2 <= in_neg2 ? c2e : c2s;
      // a falling coordinate counts down from the full span
      q1    <= in_neg1 ? c1s - c1e : '0;
      q2    <= in_neg2 ? c2s - c2e : '0;
      r1    <= {1'b0, t_hi_in - t_lo_in};
      r2    <= {1'b0, t_hi_in - t_lo_in};
    end else if (cmd.emit) begin
      t  <= t + coord_t'(1);
      q1 <= nxt1.q;
      r1 <= nxt1.r;
      q2 <= nxt2.q;
      r2 <= nxt2.r;
    end
    if (cmd.div_start) begin
      div_sel <= cmd.div_sel;
    end
    if (div_done) begin
      if (div_sel) begin
        sq2 <= div_quot;
        sr2 <= div_rem;
      end else begin
        sq1 <= div_quot;
        sr1 <= div_rem;
      end
    end
  end

  lpi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel ? mag2 : mag1),
    .divisor  (dspan),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign nxt1 = advance(q1, r1, sq1, sr1, neg1, dspan);
  assign nxt2 = advance(q2, r2, sq2, sr2, neg2, dspan);
  assign v1   = base1 + q1;
  assign v2   = base2 + q2;

  always_comb begin
    case (axis)
      AXIS_Y: begin
        px = v1; py = t; pz = v2;
      end
      AXIS_X: begin
        px = t; py = v1; pz = v2;
      end
      AXIS_Z: begin
        px = v1; py = v2; pz = t;
      end
      default: begin
        px = v1; py = t; pz = v2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      point_x    <= px;
      point_y    <= py;
      point_z    <= pz;
      last_point <= (t == t_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.degenerate = (ca_x == cb_x) && (ca_y == cb_y) && (ca_z == cb_z);
  assign status.div_done   = div_done && !div_busy;
  assign status.slot_free  = !out_valid || out_ready;
  assign status.last       = (t == t_hi);

endmodule

// ----- rtl/lpi_ctrl.sv -----
// Controller state machine: sequences accept, the two slope divisions and
// the point run. Depends on lpi_pkg for state, command and status types.
module lpi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpi_pkg::lpi_status_t status,
  output lpi_pkg::lpi_cmd_t    cmd
);
  import lpi_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !status.degenerate) state_next = ST_DIV1;
      end
      ST_DIV1:  state_next = ST_WAIT1;
      ST_WAIT1: begin
        if (status.div_done) state_next = ST_DIV2;
      end
      ST_DIV2:  state_next = ST_WAIT2;
      ST_WAIT2: begin
        if (status.div_done) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.slot_free && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = 1'b0;
    cmd.emit      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV1: begin
        cmd.div_start = 1'b1;
      end
      ST_DIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      ST_RUN: begin
        // hold the point while the output register is still occupied
        cmd.emit = status.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.slot_free)
    else $error("point emitted into an occupied output register");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && status.slot_free && status.last |=> (state == ST_IDLE))
    else $error("run did not finish after the last point");

  a_start_pulse: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !cmd.div_start)
    else $error("divider start held for more than one cycle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == ST_WAIT1) || (state == ST_WAIT2))
    else $error("divider finished outside a wait state");

endmodule

// ----- rtl/line_point_interpolator_core.sv -----
// Line point interpolator: emits the integer points of a 3D line between
// two endpoints. The two coordinate slopes are computed in turn by the
// shared serial divider, then the stepping loop emits one point per cycle
// while the output register is free to take it. Identical endpoints are
// accepted in idle and emit no point.
// Synchronous reset returns the controller to idle and empties the output.
module line_point_interpolator_core #(
  parameter int COORD_MAX = lpi_pkg::LPI_COORD_MAX
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lpi_pkg::coord_t a_x,
  input  lpi_pkg::coord_t a_y,
  input  lpi_pkg::coord_t a_z,
  input  lpi_pkg::coord_t b_x,
  input  lpi_pkg::coord_t b_y,
  input  lpi_pkg::coord_t b_z,
  output logic            out_valid,
  input  logic            out_ready,
  output lpi_pkg::coord_t point_x,
  output lpi_pkg::coord_t point_y,
  output lpi_pkg::coord_t point_z,
  output logic            last_point
);
  import lpi_pkg::*;

  lpi_cmd_t    cmd;
  lpi_status_t status;

  lpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lpi_datapath #(
    .COORD_MAX (COORD_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .a_x        (a_x),
    .a_y        (a_y),
    .a_z        (a_z),
    .b_x        (b_x),
    .b_y        (b_y),
    .b_z        (b_z),
    .cmd        (cmd),
    .status     (status),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last_point (last_point),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule
